// ===== design/slcd_pkg.sv =====
package slcd_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    // wide enough for a payload length of up to 127
    localparam int PLEN_W = 7;
    localparam int OUT_IDX_W = 5;

    typedef struct packed {
        logic              bank;
        logic [PLEN_W-1:0] plen;
    } t_desc;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    typedef struct packed {
        logic              en;
        logic              bank;
        logic [PLEN_W-1:0] idx;
        logic [7:0]        data;
    } t_mem_wr;

endpackage

// ===== design/slcd_front.sv =====
module slcd_front
    import slcd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_stall,
    input  logic [7:0] i_first_sync,
    input  logic [7:0] i_second_sync,
    input  logic [7:0] i_accept_type,
    output t_mem_wr    o_wr,
    output logic       o_push,
    output t_desc      o_push_desc,
    input  t_release   i_release
);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {PH_SYNC1, PH_SYNC2, PH_LEN, PH_BODY} t_phase;

    t_phase      r_phase;
    logic [7:0]  r_len;
    logic [7:0]  r_pos;
    logic [15:0] r_crc;
    logic [7:0]  r_crc_lo;
    logic [7:0]  r_type;
    logic        r_wbank;
    logic [1:0]  r_busy;
    logic [1:0]  n_busy;

    logic        in_acc;
    logic        in_data;
    logic        at_crc_lo;
    logic        len_ok;
    logic        good;
    logic [15:0] crc_next;

    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    assign o_stall   = (r_phase == PH_BODY) && r_busy[r_wbank];
    assign in_acc    = i_valid && !o_stall;
    assign in_data   = r_pos < r_len;
    assign at_crc_lo = r_pos == r_len;
    assign crc_next  = crc_feed(r_crc, i_rx_byte);
    assign len_ok    = (i_rx_byte != 8'd0) && ({1'b0, i_rx_byte} <= 9'(MAX_PAYLOAD + 1));
    assign good      = ({i_rx_byte, r_crc_lo} == r_crc) && (r_type == i_accept_type)
                       && (r_len >= 8'd2);

    always_comb begin
        o_wr.en   = in_acc && (r_phase == PH_BODY) && in_data && (r_pos != 8'd0);
        o_wr.bank = r_wbank;
        o_wr.idx  = PLEN_W'(r_pos - 8'd1);
        o_wr.data = i_rx_byte;

        o_push           = in_acc && (r_phase == PH_BODY) && !in_data && !at_crc_lo && good;
        o_push_desc.bank = r_wbank;
        o_push_desc.plen = PLEN_W'(r_len - 8'd1);

        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (o_push) begin
            n_busy[r_wbank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC1;
            r_len    <= 8'd0;
            r_pos    <= 8'd0;
            r_crc    <= CRC_INIT;
            r_crc_lo <= 8'd0;
            r_type   <= 8'd0;
            r_wbank  <= 1'b0;
            r_busy   <= 2'b00;
        end else begin
            r_busy <= n_busy;
            if (in_acc) begin
                case (r_phase)
                    PH_SYNC1: begin
                        if (i_rx_byte == i_first_sync) begin
                            r_phase <= PH_SYNC2;
                        end
                    end
                    PH_SYNC2: begin
                        // a mismatch is not retried as a first sync byte
                        r_phase <= (i_rx_byte == i_second_sync) ? PH_LEN : PH_SYNC1;
                    end
                    PH_LEN: begin
                        r_len   <= i_rx_byte;
                        r_pos   <= 8'd0;
                        r_crc   <= CRC_INIT;
                        r_phase <= len_ok ? PH_BODY : PH_SYNC1;
                    end
                    PH_BODY: begin
                        if (in_data) begin
                            if (r_pos == 8'd0) begin
                                r_type <= i_rx_byte;
                            end
                            r_crc <= crc_next;
                        end else if (at_crc_lo) begin
                            r_crc_lo <= i_rx_byte;
                        end else begin
                            // hand the filled bank to the drain side
                            if (good) begin
                                r_wbank <= ~r_wbank;
                            end
                            r_phase <= PH_SYNC1;
                        end
                        r_pos <= r_pos + 8'd1;
                    end
                    default: begin
                        r_phase <= PH_SYNC1;
                    end
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    a_write_free_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.en || o_push) |-> !r_busy[r_wbank])
        else $error("payload bank written while still draining");
`endif

endmodule

// ===== design/slcd_queue.sv =====
module slcd_queue
    import slcd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output t_desc o_head,
    output logic  o_empty
);

    t_desc      r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       full;

    assign o_empty = r_cnt == 2'd0;
    assign full    = r_cnt == 2'd2;
    assign o_head  = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !full)
        else $error("frame queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("frame queue underflow");
`endif

endmodule

// ===== design/slcd_back.sv =====
module slcd_back
    import slcd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mem_wr              i_wr,
    input  logic                 i_q_empty,
    input  t_desc                i_q_head,
    output logic                 o_q_pop,
    output t_release             o_release,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_item_byte,
    output logic [OUT_IDX_W-1:0] o_byte_index,
    output logic [OUT_IDX_W-1:0] o_data_count,
    output logic                 o_last
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]           r_mem [2][MAX_PAYLOAD];
    logic                 r_active;
    logic                 r_bank;
    logic [PLEN_W-1:0]    r_plen;
    logic [PLEN_W-1:0]    r_k;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic [OUT_IDX_W-1:0] r_out_idx;
    logic [OUT_IDX_W-1:0] r_out_dc;
    logic                 r_out_last;

    logic issue;
    logic last_k;

    assign issue   = r_active && (!r_out_valid || !i_stall);
    assign last_k  = r_k == (r_plen - PLEN_W'(1));
    assign o_q_pop = !r_active && !i_q_empty;

    assign o_release.valid = issue && last_k;
    assign o_release.bank  = r_bank;

    assign o_valid      = r_out_valid;
    assign o_item_byte  = r_out_byte;
    assign o_byte_index = r_out_idx;
    assign o_data_count = r_out_dc;
    assign o_last       = r_out_last;

    // payload memory: front writes one bank, the drain reads the other
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.bank][i_wr.idx[IDX_W-1:0]] <= i_wr.data;
        end
        if (issue) begin
            r_out_byte <= r_mem[r_bank][r_k[IDX_W-1:0]];
            r_out_idx  <= r_k[OUT_IDX_W-1:0];
            r_out_dc   <= OUT_IDX_W'(r_plen - PLEN_W'(1));
            r_out_last <= last_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_bank      <= 1'b0;
            r_plen      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_active <= 1'b1;
                r_bank   <= i_q_head.bank;
                r_plen   <= i_q_head.plen;
                r_k      <= '0;
            end else if (issue) begin
                r_k <= r_k + PLEN_W'(1);
                if (last_k) begin
                    r_active <= 1'b0;
                end
            end
            if (issue) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_pop_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_active && (r_k == '0))
        else $error("drain did not start after pop");
    a_last_only_at_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> (r_out_last == $past(o_release.valid)))
        else $error("last flag does not match bank release");
`endif

endmodule

// ===== design/sync_length_crc_deframer.sv =====
// Drain start: for a good frame, the queue registers the descriptor, the drain pops it
//   into its control, then registers the first payload byte at the output (drain side idle).
// Throughput: one received byte per cycle; payload bytes leave at one per cycle while i_stall
//   is low. Input stalls in the frame body while both payload banks still wait to drain.
// Reset (synchronous, active low) clears parser, queue and drain control and loads the
//   sync registers with 0xAA and 0x55 and the accepted type with 0; payload memory is not cleared.
module sync_length_crc_deframer
    import slcd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_item_byte,
    output logic [OUT_IDX_W-1:0] o_byte_index,
    output logic [OUT_IDX_W-1:0] o_data_count,
    output logic                 o_last,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic [1:0] REG_FIRST_SYNC  = 2'd0;
    localparam logic [1:0] REG_SECOND_SYNC = 2'd1;
    localparam logic [1:0] REG_ACCEPT_TYPE = 2'd2;

    logic [7:0] r_first_sync;
    logic [7:0] r_second_sync;
    logic [7:0] r_accept_type;
    logic       cfg_wr;

    t_mem_wr  wr;
    logic     push;
    t_desc    push_desc;
    t_release release_bank;
    logic     q_pop;
    t_desc    q_head;
    logic     q_empty;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_sync  <= 8'hAA;
            r_second_sync <= 8'h55;
            r_accept_type <= 8'h00;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_FIRST_SYNC:  r_first_sync  <= pwdata[7:0];
                REG_SECOND_SYNC: r_second_sync <= pwdata[7:0];
                REG_ACCEPT_TYPE: r_accept_type <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FIRST_SYNC:  prdata = {24'd0, r_first_sync};
            REG_SECOND_SYNC: prdata = {24'd0, r_second_sync};
            REG_ACCEPT_TYPE: prdata = {24'd0, r_accept_type};
            default:         prdata = 32'd0;
        endcase
    end

    slcd_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_rx_byte     (i_rx_byte),
        .o_stall       (o_stall),
        .i_first_sync  (r_first_sync),
        .i_second_sync (r_second_sync),
        .i_accept_type (r_accept_type),
        .o_wr          (wr),
        .o_push        (push),
        .o_push_desc   (push_desc),
        .i_release     (release_bank)
    );

    slcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    slcd_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (wr),
        .i_q_empty    (q_empty),
        .i_q_head     (q_head),
        .o_q_pop      (q_pop),
        .o_release    (release_bank),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_item_byte  (o_item_byte),
        .o_byte_index (o_byte_index),
        .o_data_count (o_data_count),
        .o_last       (o_last)
    );

endmodule
